[src/tsci_pkg.sv]
package tsci_pkg;

    // Width of a cursor or cell position field
    localparam int POS_W = 4;

    // Action codes of an input item
    localparam logic [1:0] ACT_FEED = 2'd0;
    localparam logic [1:0] ACT_READ = 2'd1;
    localparam logic [1:0] ACT_NEW  = 2'd2;

    // Stream characters
    localparam logic [7:0] CH_CARET = 8'h5E;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_C     = 8'h63;
    localparam logic [7:0] CH_D     = 8'h64;
    localparam logic [7:0] CH_E     = 8'h65;
    localparam logic [7:0] CH_H     = 8'h68;
    localparam logic [7:0] CH_I     = 8'h69;
    localparam logic [7:0] CH_L     = 8'h6C;
    localparam logic [7:0] CH_O     = 8'h6F;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_U     = 8'h75;

    // Largest value a single digit can give
    localparam logic [POS_W-1:0] DIGIT_MAX = POS_W'(9);

    // Screen update operations
    typedef enum logic [2:0] {
        SCR_NONE,
        SCR_WRITE,
        SCR_INSERT,
        SCR_ERASE,
        SCR_CLEAR
    } scr_op_t;

    typedef struct packed {
        scr_op_t          op;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic [7:0]       ch;
    } scr_ctl_t;

endpackage

[src/tsci_screen.sv]
module tsci_screen #(
    parameter int ROWS = 10,
    parameter int COLS = 10
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  tsci_pkg::scr_ctl_t      ctl,
    input  logic [tsci_pkg::POS_W-1:0] rd_row,
    input  logic [tsci_pkg::POS_W-1:0] rd_col,
    output logic [7:0]              rd_char
);
    import tsci_pkg::*;

    localparam int ROW_IW = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int COL_IW = (COLS > 1) ? $clog2(COLS) : 1;

    logic [7:0] screen_reg  [ROWS][COLS];
    logic [7:0] screen_next [ROWS][COLS];

    // Apply the update to every cell in parallel
    always_comb
    begin
        for (int r = 0; r < ROWS; r++)
        begin
            for (int c = 0; c < COLS; c++)
            begin
                screen_next[r][c] = screen_reg[r][c];
                if (ctl.op == SCR_CLEAR)
                begin
                    screen_next[r][c] = CH_SPACE;
                end
                else if (ctl.row == POS_W'(r))
                begin
                    case (ctl.op)
                        SCR_WRITE, SCR_INSERT:
                        begin
                            if (ctl.col == POS_W'(c))
                            begin
                                screen_next[r][c] = ctl.ch;
                            end
                        end
                        SCR_ERASE:
                        begin
                            if (POS_W'(c) >= ctl.col)
                            begin
                                screen_next[r][c] = CH_SPACE;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            // Shift the tail of the row right; the last cell drops out
            for (int c = 1; c < COLS; c++)
            begin
                if (ctl.op == SCR_INSERT && ctl.row == POS_W'(r) && POS_W'(c) > ctl.col)
                begin
                    screen_next[r][c] = screen_reg[r][c-1];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < ROWS; r++)
            begin
                for (int c = 0; c < COLS; c++)
                begin
                    screen_reg[r][c] <= CH_SPACE;
                end
            end
        end
        else
        begin
            for (int r = 0; r < ROWS; r++)
            begin
                for (int c = 0; c < COLS; c++)
                begin
                    screen_reg[r][c] <= screen_next[r][c];
                end
            end
        end
    end

    // Read one cell; positions off the screen answer zero
    always_comb
    begin
        rd_char = 8'd0;
        if (rd_row < POS_W'(ROWS) && rd_col < POS_W'(COLS))
        begin
            rd_char = screen_reg[rd_row[ROW_IW-1:0]][rd_col[COL_IW-1:0]];
        end
    end

endmodule

[src/text_screen_control_interpreter_core.sv]
// Character-cell screen driven by a byte stream with caret escapes.
//
// Input channel s_*: one item per handshake carries an action (feed a stream
// byte, read one cell, start a new session), the stream byte and a cell
// position for reads. Output channel m_*: exactly one item per input item,
// in order, with the read character (zero unless the action was a read),
// the cursor position, the insert flag and the escape phase after the item.
//
// An accepted item lands in an input register; when it advances, the screen,
// cursor and escape state are updated and the result register is loaded,
// which drives m_tvalid. Both stages advance together whenever the result
// slot is empty or being taken, giving one item per cycle sustained while
// m_tready stays high; the screen is a bank of registers updated a whole
// row or the whole screen at once, so no item takes longer than another.
//
// Reset blanks the screen to spaces, homes the cursor and selects overwrite
// mode; a new-session item does the same. When m_tready is low the result
// register holds, then the input register fills and s_tready drops.
module text_screen_control_interpreter_core #(
    parameter int ROWS = 10,
    parameter int COLS = 10
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,  // action[1:0], byte_in[9:2], read_row[13:10],
                                  // read_col[17:14], zero[23:18]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata   // cell_char[7:0], cursor_row_out[11:8],
                                  // cursor_col_out[15:12], insert_active[16],
                                  // escape_phase_out[18:17], zero[23:19]
);
    import tsci_pkg::*;

    localparam logic [POS_W-1:0] ROW_MAX = POS_W'(ROWS - 1);
    localparam logic [POS_W-1:0] COL_MAX = POS_W'(COLS - 1);

    typedef enum logic [1:0] {
        ESC_IDLE  = 2'd0,
        ESC_CARET = 2'd1,
        ESC_COL   = 2'd2
    } esc_state_t;

    // Input register
    logic             in_valid_reg, in_valid_next;
    logic [1:0]       in_action_reg;
    logic [7:0]       in_byte_reg;
    logic [POS_W-1:0] in_row_reg;
    logic [POS_W-1:0] in_col_reg;

    // Interpreter state
    logic [POS_W-1:0] cursor_row_reg, cursor_row_next;
    logic [POS_W-1:0] cursor_col_reg, cursor_col_next;
    logic [POS_W-1:0] pending_row_reg, pending_row_next;
    logic             insert_reg, insert_next;
    esc_state_t       escape_reg, escape_next;

    // Result register
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       cell_reg, cell_next;

    logic             in_take;
    logic             advance;
    scr_ctl_t         ctl;
    scr_ctl_t         scr_ctl;
    logic [7:0]       rd_char;
    logic [POS_W-1:0] col_adv;
    logic [7:0]       digit_val;
    logic [POS_W-1:0] digit_lo;
    logic             is_digit;
    logic [POS_W-1:0] row_sat;
    logic [POS_W-1:0] col_byte;
    logic [POS_W-1:0] col_sat;

    // Handshake: both stages move together whenever the result slot frees
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign in_take  = s_tvalid && s_tready;

    assign in_valid_next  = in_take ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign out_valid_next = advance ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);

    // Digit decoding for row and column positioning
    assign digit_val = in_byte_reg - CH_0;
    assign digit_lo  = digit_val[POS_W-1:0];
    assign is_digit  = (in_byte_reg >= CH_0) && (in_byte_reg <= CH_9);
    assign row_sat   = (digit_lo > ROW_MAX) ? ROW_MAX : digit_lo;
    assign col_byte  = (in_byte_reg < CH_0) ? '0 :
                       ((in_byte_reg > CH_9) ? DIGIT_MAX : digit_lo);
    assign col_sat   = (col_byte > COL_MAX) ? COL_MAX : col_byte;
    assign col_adv   = (cursor_col_reg < COL_MAX) ? cursor_col_reg + POS_W'(1)
                                                  : cursor_col_reg;

    // Interpret the item in the input register
    always_comb
    begin
        cursor_row_next  = cursor_row_reg;
        cursor_col_next  = cursor_col_reg;
        pending_row_next = pending_row_reg;
        insert_next      = insert_reg;
        escape_next      = escape_reg;
        cell_next        = 8'd0;
        ctl.op           = SCR_NONE;
        ctl.row          = cursor_row_reg;
        ctl.col          = cursor_col_reg;
        ctl.ch           = in_byte_reg;

        case (in_action_reg)
            ACT_FEED:
            begin
                case (escape_reg)
                    ESC_IDLE:
                    begin
                        if (in_byte_reg == CH_CARET)
                        begin
                            escape_next = ESC_CARET;
                        end
                        else
                        begin
                            ctl.op          = insert_reg ? SCR_INSERT : SCR_WRITE;
                            cursor_col_next = col_adv;
                        end
                    end
                    ESC_CARET:
                    begin
                        escape_next = ESC_IDLE;
                        case (in_byte_reg)
                            CH_B: cursor_col_next = '0;
                            CH_C: ctl.op = SCR_CLEAR;
                            CH_D:
                            begin
                                if (cursor_row_reg < ROW_MAX)
                                begin
                                    cursor_row_next = cursor_row_reg + POS_W'(1);
                                end
                            end
                            CH_U:
                            begin
                                if (cursor_row_reg != '0)
                                begin
                                    cursor_row_next = cursor_row_reg - POS_W'(1);
                                end
                            end
                            CH_L:
                            begin
                                if (cursor_col_reg != '0)
                                begin
                                    cursor_col_next = cursor_col_reg - POS_W'(1);
                                end
                            end
                            CH_R: cursor_col_next = col_adv;
                            CH_E: ctl.op = SCR_ERASE;
                            CH_H:
                            begin
                                cursor_row_next = '0;
                                cursor_col_next = '0;
                            end
                            CH_I: insert_next = 1'b1;
                            CH_O: insert_next = 1'b0;
                            default:
                            begin
                                if (is_digit)
                                begin
                                    cursor_row_next  = row_sat;
                                    pending_row_next = row_sat;
                                    escape_next      = ESC_COL;
                                end
                                else
                                begin
                                    ctl.op          = insert_reg ? SCR_INSERT : SCR_WRITE;
                                    cursor_col_next = col_adv;
                                end
                            end
                        endcase
                    end
                    default:
                    begin
                        // Column byte completes the positioning escape
                        cursor_row_next = pending_row_reg;
                        cursor_col_next = col_sat;
                        escape_next     = ESC_IDLE;
                    end
                endcase
            end
            ACT_READ:
            begin
                cell_next = rd_char;
            end
            ACT_NEW:
            begin
                ctl.op           = SCR_CLEAR;
                cursor_row_next  = '0;
                cursor_col_next  = '0;
                pending_row_next = '0;
                insert_next      = 1'b0;
                escape_next      = ESC_IDLE;
            end
            default:
            begin
            end
        endcase
    end

    // Only touch the screen when the item really advances
    always_comb
    begin
        scr_ctl = ctl;
        if (!advance)
        begin
            scr_ctl.op = SCR_NONE;
        end
    end

    tsci_screen #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_screen (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (scr_ctl),
        .rd_row  (in_row_reg),
        .rd_col  (in_col_reg),
        .rd_char (rd_char)
    );

    // Hold state, input and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            cursor_row_reg  <= '0;
            cursor_col_reg  <= '0;
            pending_row_reg <= '0;
            insert_reg      <= 1'b0;
            escape_reg      <= ESC_IDLE;
            in_action_reg   <= '0;
            in_byte_reg     <= '0;
            in_row_reg      <= '0;
            in_col_reg      <= '0;
            cell_reg        <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (in_take)
            begin
                in_action_reg <= s_tdata[1:0];
                in_byte_reg   <= s_tdata[9:2];
                in_row_reg    <= s_tdata[13:10];
                in_col_reg    <= s_tdata[17:14];
            end
            if (advance)
            begin
                cursor_row_reg  <= cursor_row_next;
                cursor_col_reg  <= cursor_col_next;
                pending_row_reg <= pending_row_next;
                insert_reg      <= insert_next;
                escape_reg      <= escape_next;
                cell_reg        <= cell_next;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, escape_reg, insert_reg, cursor_col_reg, cursor_row_reg,
                       cell_reg};

`ifndef SYNTHESIS
    a_row_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
        cursor_row_reg <= ROW_MAX)
        else $error("cursor row off screen");

    a_col_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
        cursor_col_reg <= COL_MAX)
        else $error("cursor column off screen");

    a_pending_row: assert property (@(posedge clk) disable iff (!rst_n)
        escape_reg == ESC_COL |-> cursor_row_reg == pending_row_reg)
        else $error("cursor row differs from pending row while awaiting column");

    a_new_session: assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_action_reg == ACT_NEW |=>
            cursor_row_reg == '0 && cursor_col_reg == '0 && !insert_reg &&
            escape_reg == ESC_IDLE)
        else $error("new session did not reset the cursor and modes");

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> in_valid_reg && out_valid_reg && !m_tready)
        else $error("input stalled without a full pipeline");
`endif

endmodule

[verif/text_screen_control_interpreter_core_tb.sv]
`timescale 1ns / 1ps

module text_screen_control_interpreter_core_tb;

    import tsci_pkg::*;

    localparam int SCR_ROWS = 10;
    localparam int SCR_COLS = 10;
    localparam int RANDOM_ITEMS = 1700;
    localparam int CYCLE_LIMIT = 400000;

    // Action code with no meaning to the block
    localparam logic [1:0] ACT_IDLE = 2'd3;

    // Escape phases as reported in each result
    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_CARET  = 2'd1;
    localparam logic [1:0] PH_COLUMN = 2'd2;

    typedef struct {
        logic [1:0]       act;
        logic [7:0]       ch;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        bit               drain;
    } term_item_t;

    typedef struct {
        logic [7:0]       glyph;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic             ins;
        logic [1:0]       phase;
    } term_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = 24'd0;  // action[1:0], byte_in[9:2], read_row[13:10],
                                   // read_col[17:14], zero[23:18]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;          // cell_char[7:0], cursor_row_out[11:8],
                                   // cursor_col_out[15:12], insert_active[16],
                                   // escape_phase_out[18:17], zero[23:19]

    // Screen model state
    logic [7:0]       scr [0:SCR_ROWS*SCR_COLS-1];
    logic [POS_W-1:0] cur_row;
    logic [POS_W-1:0] cur_col;
    logic             ins_mode;
    logic [1:0]       esc_phase;
    logic [POS_W-1:0] pend_row;

    term_item_t   stream_q [$];
    term_result_t reports_due [$];
    term_item_t   drive_item;
    term_item_t   fed_item;
    term_result_t got_rep;
    term_result_t want_rep;

    bit  item_taken = 1'b0;
    bit  drain_next = 1'b0;
    int  n_fed = 0;
    int  n_errors = 0;
    int  cycles = 0;
    int  burst_left = 0;
    int  gap_left = 0;
    int  rx_mode = 0;
    int  rx_left = 0;
    int  rx_tick = 0;

    text_screen_control_interpreter_core #(
        .ROWS(SCR_ROWS),
        .COLS(SCR_COLS)
    ) u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Screen predictor
    // ---------------------------------------------------------------

    function automatic void clear_session();
        for (int i = 0; i < SCR_ROWS * SCR_COLS; i++)
            scr[i] = CH_SPACE;
        cur_row   = '0;
        cur_col   = '0;
        ins_mode  = 1'b0;
        esc_phase = PH_IDLE;
        pend_row  = '0;
    endfunction

    // Write at the cursor, shift the row tail in insert mode, step right
    function automatic void put_glyph(logic [7:0] ch);
        int base;
        base = int'(cur_row) * SCR_COLS;
        if (ins_mode)
            for (int c = SCR_COLS - 1; c > int'(cur_col); c--)
                scr[base + c] = scr[base + c - 1];
        scr[base + int'(cur_col)] = ch;
        if (int'(cur_col) < SCR_COLS - 1)
            cur_col = cur_col + 1'b1;
    endfunction

    function automatic void run_escape(logic [7:0] ch);
        int r;
        esc_phase = PH_IDLE;
        case (ch)
            CH_B: cur_col = '0;
            CH_C:
            begin
                for (int i = 0; i < SCR_ROWS * SCR_COLS; i++)
                    scr[i] = CH_SPACE;
            end
            CH_D: if (int'(cur_row) < SCR_ROWS - 1) cur_row = cur_row + 1'b1;
            CH_U: if (cur_row > 0) cur_row = cur_row - 1'b1;
            CH_L: if (cur_col > 0) cur_col = cur_col - 1'b1;
            CH_R: if (int'(cur_col) < SCR_COLS - 1) cur_col = cur_col + 1'b1;
            CH_E:
            begin
                for (int c = int'(cur_col); c < SCR_COLS; c++)
                    scr[int'(cur_row) * SCR_COLS + c] = CH_SPACE;
            end
            CH_H:
            begin
                cur_row = '0;
                cur_col = '0;
            end
            CH_I: ins_mode = 1'b1;
            CH_O: ins_mode = 1'b0;
            default:
            begin
                if (ch >= CH_0 && ch <= CH_9)
                begin
                    // Row digit takes effect at once, then wait for the column
                    r = int'(ch - CH_0);
                    if (r > SCR_ROWS - 1)
                        r = SCR_ROWS - 1;
                    cur_row   = POS_W'(r);
                    pend_row  = POS_W'(r);
                    esc_phase = PH_COLUMN;
                end
                else
                begin
                    put_glyph(ch);
                end
            end
        endcase
    endfunction

    // Column byte saturates below and above the digit range
    function automatic void take_column(logic [7:0] ch);
        int c;
        if (ch < CH_0)
            c = 0;
        else if (ch > CH_9)
            c = int'(DIGIT_MAX);
        else
            c = int'(ch - CH_0);
        if (c > SCR_COLS - 1)
            c = SCR_COLS - 1;
        cur_row   = pend_row;
        cur_col   = POS_W'(c);
        esc_phase = PH_IDLE;
    endfunction

    function automatic term_result_t interpret_item(term_item_t it);
        term_result_t r;
        r.glyph = 8'h00;
        case (it.act)
            ACT_FEED:
            begin
                if (esc_phase == PH_IDLE)
                begin
                    if (it.ch == CH_CARET)
                        esc_phase = PH_CARET;
                    else
                        put_glyph(it.ch);
                end
                else if (esc_phase == PH_CARET)
                begin
                    run_escape(it.ch);
                end
                else
                begin
                    take_column(it.ch);
                end
            end
            ACT_READ:
            begin
                if (int'(it.row) < SCR_ROWS && int'(it.col) < SCR_COLS)
                    r.glyph = scr[int'(it.row) * SCR_COLS + int'(it.col)];
            end
            ACT_NEW: clear_session();
            default: ;
        endcase
        r.row   = cur_row;
        r.col   = cur_col;
        r.ins   = ins_mode;
        r.phase = esc_phase;
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Stimulus builders
    // ---------------------------------------------------------------

    task automatic add_item(logic [1:0] act, logic [7:0] ch,
                            logic [POS_W-1:0] row, logic [POS_W-1:0] col);
        term_item_t it;
        it.act   = act;
        it.ch    = ch;
        it.row   = row;
        it.col   = col;
        it.drain = drain_next;
        drain_next = 1'b0;
        stream_q.push_back(it);
        n_fed++;
    endtask

    // Feed items carry random junk in the read position fields
    task automatic add_feed(logic [7:0] ch);
        add_item(ACT_FEED, ch, POS_W'($urandom_range(0, 15)),
                 POS_W'($urandom_range(0, 15)));
    endtask

    task automatic add_read(int row, int col);
        add_item(ACT_READ, 8'($urandom_range(0, 255)), POS_W'(row), POS_W'(col));
    endtask

    task automatic add_action(logic [1:0] act);
        add_item(act, 8'($urandom_range(0, 255)), POS_W'($urandom_range(0, 15)),
                 POS_W'($urandom_range(0, 15)));
    endtask

    function automatic logic [7:0] pick_escape_code();
        int k;
        k = $urandom_range(0, 15);
        case (k)
            0:  return CH_B;
            1:  return ($urandom_range(0, 3) == 0) ? CH_C : CH_R;
            2:  return CH_D;
            3:  return CH_U;
            4:  return CH_L;
            5:  return CH_R;
            6:  return CH_E;
            7:  return CH_H;
            8:  return CH_I;
            9:  return CH_O;
            10: return CH_CARET;
            11: return CH_D;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [7:0] pick_column_byte();
        int k;
        k = $urandom_range(0, 3);
        if (k == 0)
            return 8'($urandom_range(0, int'(CH_0) - 1));
        else if (k == 1)
            return 8'($urandom_range(int'(CH_9) + 1, 255));
        else
            return CH_0 + 8'($urandom_range(0, 9));
    endfunction

    // ---------------------------------------------------------------
    // Sequence: reset, directed items, random items, drain, verdict
    // ---------------------------------------------------------------

    initial
    begin
        int pick;
        int stop_at;

        clear_session();

        // Directed: reset contents, out-of-range reads, byte extremes
        add_read(0, 0);
        add_read(15, 15);
        add_read(9, 10);
        add_feed(8'h00);
        add_feed(8'hFF);
        // insert mode shifts the row, overwrite restores normal writes
        add_feed(CH_CARET);
        add_feed(CH_I);
        add_feed(8'h41);
        add_read(0, 2);
        add_feed(CH_CARET);
        add_feed(CH_O);
        // doubled caret writes a caret
        add_feed(CH_CARET);
        add_feed(CH_CARET);
        // row digit, read while waiting for the column, low column byte
        add_feed(CH_CARET);
        add_feed(CH_9);
        add_read(0, 0);
        add_feed(8'h00);
        // high column byte saturates to the last column
        add_feed(CH_CARET);
        add_feed(CH_0 + 8'd3);
        add_feed(8'hFF);
        add_feed(CH_CARET);
        add_feed(CH_E);
        // cursor motion and clear
        add_feed(CH_CARET);
        add_feed(CH_D);
        add_feed(CH_CARET);
        add_feed(CH_U);
        add_feed(CH_CARET);
        add_feed(CH_L);
        add_feed(CH_CARET);
        add_feed(CH_R);
        add_feed(CH_CARET);
        add_feed(CH_B);
        add_feed(CH_CARET);
        add_feed(CH_H);
        add_feed(CH_CARET);
        add_feed(CH_C);
        // unused action and new session while an escape is open
        add_feed(CH_CARET);
        add_action(ACT_IDLE);
        add_action(ACT_NEW);

        // Random: mostly well-formed escapes and text, some broken sequences
        drain_next = 1'b1;
        stop_at = n_fed + RANDOM_ITEMS;
        while (n_fed < stop_at)
        begin
            if ($urandom_range(0, 199) == 0)
                drain_next = 1'b1;
            pick = $urandom_range(0, 99);
            if (pick < 42)
            begin
                if ($urandom_range(0, 3) == 0)
                    add_feed(8'($urandom_range(0, 255)));
                else
                    add_feed(8'($urandom_range(8'h21, 8'h7E)));
            end
            else if (pick < 66)
            begin
                add_feed(CH_CARET);
                add_feed(pick_escape_code());
            end
            else if (pick < 76)
            begin
                add_feed(CH_CARET);
                add_feed(CH_0 + 8'($urandom_range(0, 9)));
                add_feed(pick_column_byte());
            end
            else if (pick < 90)
            begin
                if ($urandom_range(0, 7) == 0)
                    add_read($urandom_range(0, 15), $urandom_range(0, 15));
                else
                    add_read($urandom_range(0, 9), $urandom_range(0, 9));
            end
            else if (pick < 94)
            begin
                // open escape interrupted by a read or an idle action
                add_feed(CH_CARET);
                if ($urandom_range(0, 1) == 0)
                    add_feed(CH_0 + 8'($urandom_range(0, 9)));
                if ($urandom_range(0, 1) == 0)
                    add_read($urandom_range(0, 9), $urandom_range(0, 9));
                else
                    add_action(ACT_IDLE);
            end
            else if (pick < 97)
            begin
                add_feed(CH_CARET);
            end
            else if (pick < 99)
            begin
                add_action(ACT_IDLE);
            end
            else
            begin
                add_action(ACT_NEW);
            end
        end

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (stream_q.size() != 0 || s_tvalid || reports_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (n_errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // ---------------------------------------------------------------
    // Driver: bursts of items with random gaps, hold until accepted
    // ---------------------------------------------------------------

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!s_tvalid || item_taken)
            begin
                item_taken = 1'b0;
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end
                else if (stream_q.size() == 0 ||
                         (stream_q[0].drain && reports_due.size() != 0))
                begin
                    s_tvalid <= 1'b0;
                end
                else
                begin
                    drive_item = stream_q.pop_front();
                    s_tdata  <= {6'b0, drive_item.col, drive_item.row,
                                 drive_item.ch, drive_item.act};
                    s_tvalid <= 1'b1;
                    if (burst_left > 0)
                    begin
                        burst_left--;
                    end
                    else
                    begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Receiver: stall pattern switches among four ready modes
    // ---------------------------------------------------------------

    always @(negedge clk)
    begin
        rx_tick++;
        if (rx_left == 0)
        begin
            rx_mode = $urandom_range(0, 3);
            rx_left = $urandom_range(30, 200);
        end
        else
        begin
            rx_left--;
        end
        case (rx_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom_range(0, 1));
            2:       m_tready <= ($urandom_range(0, 3) == 0);
            default: m_tready <= ((rx_tick % 5) != 0);
        endcase
    end

    // ---------------------------------------------------------------
    // Monitor: predict on input accept, compare on output accept
    // ---------------------------------------------------------------

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            cycles++;
            if (s_tvalid && s_tready)
            begin
                fed_item.act   = s_tdata[1:0];
                fed_item.ch    = s_tdata[9:2];
                fed_item.row   = s_tdata[13:10];
                fed_item.col   = s_tdata[17:14];
                fed_item.drain = 1'b0;
                reports_due.push_back(interpret_item(fed_item));
                item_taken = 1'b1;
            end
            if (m_tvalid && m_tready)
            begin
                got_rep.glyph = m_tdata[7:0];
                got_rep.row   = m_tdata[11:8];
                got_rep.col   = m_tdata[15:12];
                got_rep.ins   = m_tdata[16];
                got_rep.phase = m_tdata[18:17];
                if (reports_due.size() == 0)
                begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("unexpected item: glyph %h row %0d col %0d ins %0d phase %0d",
                                 got_rep.glyph, got_rep.row, got_rep.col, got_rep.ins,
                                 got_rep.phase);
                end
                else
                begin
                    want_rep = reports_due.pop_front();
                    if (got_rep.glyph !== want_rep.glyph || got_rep.row !== want_rep.row ||
                        got_rep.col !== want_rep.col || got_rep.ins !== want_rep.ins ||
                        got_rep.phase !== want_rep.phase)
                    begin
                        n_errors++;
                        if (n_errors <= 10)
                            $display("mismatch at cycle %0d: ", cycles,
                                     "expected glyph %h row %0d col %0d ins %0d phase %0d, ",
                                     want_rep.glyph, want_rep.row, want_rep.col,
                                     want_rep.ins, want_rep.phase,
                                     "got glyph %h row %0d col %0d ins %0d phase %0d",
                                     got_rep.glyph, got_rep.row, got_rep.col,
                                     got_rep.ins, got_rep.phase);
                    end
                end
            end
            if (cycles > CYCLE_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

endmodule
